>>> hw/rtl/emfd_pkg.sv
// Shared types, constants and register codes for the energy meter frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package emfd_pkg;

    localparam int FRAME_BYTES = 24;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 2);
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    localparam int GAIN_W  = 18;
    localparam int LIMIT_W = 8;
    localparam int REG24_W = 24;
    localparam int PROD_W  = REG24_W + GAIN_W;
    localparam int WIDE_W  = PROD_W + GAIN_W;
    localparam int FRAC_W  = 16;
    localparam int DIVR_W  = REG24_W + FRAC_W;
    localparam int Q_W     = 32;
    localparam int SPLIT   = 21;

    localparam int OFS_HEAD  = 0;
    localparam int OFS_SYNC  = 1;
    localparam int OFS_VP    = 2;
    localparam int OFS_VR    = 5;
    localparam int OFS_CP    = 8;
    localparam int OFS_CR    = 11;
    localparam int OFS_PP    = 14;
    localparam int OFS_PR    = 17;
    localparam int OFS_PULSE = 21;

    localparam logic [7:0] SYNC_BYTE   = 8'h5a;
    localparam logic [7:0] ERR_BYTE    = 8'haa;
    localparam logic [7:0] NOLOAD_BYTE = 8'hf0;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOLOAD  = 2'd1;
    localparam logic [1:0] STATUS_DATAERR = 2'd2;
    localparam logic [1:0] STATUS_ZERODIV = 2'd3;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [1:0] PH_V = 2'd0;
    localparam logic [1:0] PH_C = 2'd1;
    localparam logic [1:0] PH_P = 2'd2;

    localparam logic [2:0] MUL_V  = 3'd0;
    localparam logic [2:0] MUL_C  = 3'd1;
    localparam logic [2:0] MUL_PC = 3'd2;
    localparam logic [2:0] MUL_LO = 3'd3;
    localparam logic [2:0] MUL_HI = 3'd4;

    localparam int APB_AW = 4;
    localparam logic [1:0] REG_VGAIN = 2'd0;
    localparam logic [1:0] REG_CGAIN = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    localparam logic [GAIN_W-1:0]  VGAIN_RST = 18'd123208;
    localparam logic [GAIN_W-1:0]  CGAIN_RST = 18'd21823;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 8'd5;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] voltage_q16;
        logic [31:0] current_q16;
        logic [31:0] power_q16;
        logic [15:0] pulse_count;
    } out_t;

    typedef struct packed {
        logic       accept;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       div_start;
        logic       res_load;
        logic [1:0] phase;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic frame_done;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/emfd_div.sv
// Bit-serial restoring divider with 32-bit saturating quotient.
`timescale 1ns / 1ps
`default_nettype none
module emfd_div
    import emfd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [WIDE_W-1:0] dividend,
    input  wire logic [DIVR_W-1:0] divisor,
    output logic                   done,
    output logic [Q_W-1:0]         quotient
);

    localparam int STEPS = Q_W;
    localparam int SC_W  = $clog2(STEPS + 1);

    logic [SC_W-1:0]   cnt_reg;
    logic              done_reg;
    logic              ovf_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] dvs_reg;
    logic [Q_W-1:0]    num_reg;
    logic [Q_W-1:0]    q_reg;

    logic [DIVR_W:0] trial;
    logic [DIVR_W:0] diff;
    logic            fits;

    assign trial = {rem_reg, num_reg[Q_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == SC_W'(1));
            if (start) begin
                cnt_reg <= SC_W'(STEPS);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - SC_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ovf_reg <= DIVR_W'(dividend[WIDE_W-1:Q_W]) >= divisor;
            rem_reg <= DIVR_W'(dividend[WIDE_W-1:Q_W]);
            num_reg <= dividend[Q_W-1:0];
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
            num_reg <= {num_reg[Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[Q_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = ovf_reg ? '1 : q_reg;

endmodule
`default_nettype wire

>>> hw/rtl/emfd_dp.sv
// Datapath: frame store, framing counters, shared multiplier, divider and result register.
`timescale 1ns / 1ps
`default_nettype none
module emfd_dp
    import emfd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    input  wire in_t                s_data,
    input  wire logic [GAIN_W-1:0]  voltage_gain,
    input  wire logic [GAIN_W-1:0]  current_gain,
    input  wire logic [LIMIT_W-1:0] idle_limit,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_t                    m_data
);

    logic [7:0]         store_reg [FRAME_BYTES];
    logic [CNT_W-1:0]   byte_count_reg, byte_count_next;
    logic [LIMIT_W-1:0] idle_timer_reg, idle_timer_next;
    logic               receiving_reg, receiving_next;

    logic [PROD_W-1:0]  prod_reg;
    logic [WIDE_W-1:0]  acc_reg;
    logic [Q_W-1:0]     volt_reg, curr_reg, pow_reg;
    logic               m_valid_reg;
    out_t               m_data_reg;

    logic [LIMIT_W-1:0] tick_inc;
    logic               closes, frame_ok, is_byte;
    logic [REG24_W-1:0] vp, vr, cp, cr, pp, pr;
    logic [7:0]         head;
    logic [REG24_W-1:0] mul_a;
    logic [GAIN_W-1:0]  mul_b;
    logic [PROD_W-1:0]  product;
    logic [WIDE_W-1:0]  div_dividend;
    logic [DIVR_W-1:0]  div_divisor;
    logic               div_done;
    logic [Q_W-1:0]     quotient;
    logic               err, noload, zdiv;
    logic [1:0]         status;

    assign head = store_reg[OFS_HEAD];
    assign vp = {store_reg[OFS_VP], store_reg[OFS_VP+1], store_reg[OFS_VP+2]};
    assign vr = {store_reg[OFS_VR], store_reg[OFS_VR+1], store_reg[OFS_VR+2]};
    assign cp = {store_reg[OFS_CP], store_reg[OFS_CP+1], store_reg[OFS_CP+2]};
    assign cr = {store_reg[OFS_CR], store_reg[OFS_CR+1], store_reg[OFS_CR+2]};
    assign pp = {store_reg[OFS_PP], store_reg[OFS_PP+1], store_reg[OFS_PP+2]};
    assign pr = {store_reg[OFS_PR], store_reg[OFS_PR+1], store_reg[OFS_PR+2]};

    assign is_byte  = (s_data.action == ACT_BYTE);
    assign tick_inc = (idle_timer_reg == '1) ? idle_timer_reg : idle_timer_reg + LIMIT_W'(1);
    assign closes   = receiving_reg && (tick_inc > idle_limit);
    assign frame_ok = (byte_count_reg == CNT_W'(FRAME_BYTES))
                      && (store_reg[OFS_SYNC] == SYNC_BYTE);

    assign stat.frame_done = !is_byte && closes && frame_ok;
    assign stat.div_done   = div_done;
    assign stat.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        byte_count_next = byte_count_reg;
        idle_timer_next = idle_timer_reg;
        receiving_next  = receiving_reg;
        if (cmd.accept) begin
            if (is_byte) begin
                idle_timer_next = '0;
                receiving_next  = 1'b1;
                if (byte_count_reg < CNT_W'(FRAME_BYTES)) begin
                    byte_count_next = byte_count_reg + CNT_W'(1);
                end else begin
                    byte_count_next = CNT_W'(FRAME_BYTES + 1);
                end
            end else if (receiving_reg) begin
                if (closes) begin
                    idle_timer_next = '0;
                    byte_count_next = '0;
                    receiving_next  = 1'b0;
                end else begin
                    idle_timer_next = tick_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            idle_timer_reg <= '0;
            receiving_reg  <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            idle_timer_reg <= idle_timer_next;
            receiving_reg  <= receiving_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && is_byte && (byte_count_reg < CNT_W'(FRAME_BYTES))) begin
            store_reg[byte_count_reg[IDX_W-1:0]] <= s_data.rx_byte;
        end
    end

    always_comb begin
        case (cmd.mul_sel)
            MUL_V: begin
                mul_a = vp;
                mul_b = voltage_gain;
            end
            MUL_C: begin
                mul_a = cp;
                mul_b = current_gain;
            end
            MUL_PC: begin
                mul_a = pp;
                mul_b = current_gain;
            end
            MUL_LO: begin
                mul_a = REG24_W'(prod_reg[SPLIT-1:0]);
                mul_b = voltage_gain;
            end
            MUL_HI: begin
                mul_a = REG24_W'(prod_reg[PROD_W-1:SPLIT]);
                mul_b = voltage_gain;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            case (cmd.mul_sel)
                MUL_V, MUL_C, MUL_PC: prod_reg <= product;
                MUL_LO:               acc_reg  <= WIDE_W'(product);
                MUL_HI:               acc_reg  <= acc_reg + (WIDE_W'(product) << SPLIT);
                default:              acc_reg  <= acc_reg;
            endcase
        end
    end

    always_comb begin
        case (cmd.phase)
            PH_V: begin
                div_dividend = WIDE_W'(prod_reg);
                div_divisor  = DIVR_W'(vr);
            end
            PH_C: begin
                div_dividend = WIDE_W'(prod_reg);
                div_divisor  = DIVR_W'(cr);
            end
            default: begin
                div_dividend = acc_reg;
                div_divisor  = {pr, FRAC_W'(0)};
            end
        endcase
    end

    emfd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            case (cmd.phase)
                PH_V:    volt_reg <= quotient;
                PH_C:    curr_reg <= quotient;
                default: pow_reg  <= quotient;
            endcase
        end
    end

    assign err    = (head == ERR_BYTE);
    assign noload = (head > NOLOAD_BYTE);
    assign zdiv   = (vr == '0) || (cr == '0) || (!noload && (pr == '0));

    always_comb begin
        if (err) begin
            status = STATUS_DATAERR;
        end else if (zdiv) begin
            status = STATUS_ZERODIV;
        end else if (noload) begin
            status = STATUS_NOLOAD;
        end else begin
            status = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.status      <= status;
            m_data_reg.voltage_q16 <= err ? '0 : volt_reg;
            m_data_reg.current_q16 <= err ? '0 : curr_reg;
            m_data_reg.power_q16   <= (status == STATUS_OK) ? pow_reg : '0;
            m_data_reg.pulse_count <= err ? '0
                                      : {store_reg[OFS_PULSE], store_reg[OFS_PULSE+1]};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !receiving_reg |-> (byte_count_reg == '0) && (idle_timer_reg == '0))
        else $error("counters not clear while idle");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= CNT_W'(FRAME_BYTES + 1))
        else $error("byte count out of range");

    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("loaded result not presented");

endmodule
`default_nettype wire

>>> hw/rtl/emfd_ctrl.sv
// Controller: sequences framing, the three multiply/divide passes and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module emfd_ctrl
    import emfd_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MUL      = 3'd1;
    localparam logic [2:0] S_MUL_LO   = 3'd2;
    localparam logic [2:0] S_MUL_HI   = 3'd3;
    localparam logic [2:0] S_DIV_GO   = 3'd4;
    localparam logic [2:0] S_DIV_WAIT = 3'd5;
    localparam logic [2:0] S_OUT      = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        s_ready       = 1'b0;
        cmd           = '0;
        cmd.phase     = phase_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && stat.frame_done) begin
                    phase_next = PH_V;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_en = 1'b1;
                case (phase_reg)
                    PH_V:    cmd.mul_sel = MUL_V;
                    PH_C:    cmd.mul_sel = MUL_C;
                    default: cmd.mul_sel = MUL_PC;
                endcase
                state_next = (phase_reg == PH_P) ? S_MUL_LO : S_DIV_GO;
            end
            S_MUL_LO: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LO;
                state_next  = S_MUL_HI;
            end
            S_MUL_HI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_HI;
                state_next  = S_DIV_GO;
            end
            S_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (stat.div_done) begin
                    cmd.res_load = 1'b1;
                    if (phase_reg == PH_P) begin
                        state_next = S_OUT;
                    end else begin
                        phase_next = phase_reg + 2'd1;
                        state_next = S_MUL;
                    end
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_V;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> (state_reg == S_DIV_WAIT))
        else $error("divider started without waiting");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result overwritten before taken");

    a_last_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV_WAIT) && stat.div_done && (phase_reg == PH_P)
        |=> (state_reg == S_OUT))
        else $error("power pass did not end in hand-off");

endmodule
`default_nettype wire

>>> hw/rtl/energy_meter_frame_decoder_top.sv
// Top level: request channels, APB configuration registers, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// A received byte or a millisecond tick is taken while the controller is idle.
// A tick that closes a well-formed 24-byte frame holds s_ready low while the decode
// runs, and longer if an earlier result still waits on m_ready: three passes through
// one 24x18 multiplier and a one-bit-per-cycle divider (power takes two extra
// multiply steps on the low and high halves of its first product), then a load of
// the output register. The result sits in that register, so bytes and ticks are
// taken again while it waits on m_ready. Gains and idle limit sit at APB byte offsets
// 0x0, 0x4 and 0x8.
module energy_meter_frame_decoder_top
    import emfd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_t               s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_t                   m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [GAIN_W-1:0]  voltage_gain_reg;
    logic [GAIN_W-1:0]  current_gain_reg;
    logic [LIMIT_W-1:0] idle_limit_reg;
    logic               wr_en;
    cmd_t               cmd;
    stat_t              stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voltage_gain_reg <= VGAIN_RST;
            current_gain_reg <= CGAIN_RST;
            idle_limit_reg   <= LIMIT_RST;
        end else if (wr_en) begin
            case (paddr[APB_AW-1:2])
                REG_VGAIN: voltage_gain_reg <= pwdata[GAIN_W-1:0];
                REG_CGAIN: current_gain_reg <= pwdata[GAIN_W-1:0];
                REG_LIMIT: idle_limit_reg   <= pwdata[LIMIT_W-1:0];
                default:   idle_limit_reg   <= idle_limit_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[APB_AW-1:2])
            REG_VGAIN: prdata = 32'(voltage_gain_reg);
            REG_CGAIN: prdata = 32'(current_gain_reg);
            REG_LIMIT: prdata = 32'(idle_limit_reg);
            default:   prdata = '0;
        endcase
    end

    emfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    emfd_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_data       (s_data),
        .voltage_gain (voltage_gain_reg),
        .current_gain (current_gain_reg),
        .idle_limit   (idle_limit_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule
`default_nettype wire
